@@ design/lcps_pkg.sv @@
package lcps_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF = 188;
    localparam int unsigned NUM_ROWS        = 3;
    localparam int unsigned PULSE_CENTRE    = 1500;
    localparam int unsigned BORDER_MARGIN   = 10;

    localparam logic [7:0] NO_EDGE   = 8'd255;
    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [7:0] MIN_BLACK = 8'd3;
    localparam logic [7:0] MAX_BLACK = 8'd10;

    typedef enum logic [1:0] {
        SRC_TOP    = 2'd0,
        SRC_MIDDLE = 2'd1,
        SRC_BOTTOM = 2'd2,
        SRC_HELD   = 2'd3
    } src_t;

    typedef enum logic [7:0] {
        REG_TOP_ROW    = 8'd0,
        REG_MIDDLE_ROW = 8'd1,
        REG_BOTTOM_ROW = 8'd2,
        REG_PROP_GAIN  = 8'd3,
        REG_DERIV_GAIN = 8'd4
    } reg_idx_t;

    typedef struct packed {
        logic [5:0]  top_row;
        logic [5:0]  middle_row;
        logic [5:0]  bottom_row;
        logic [15:0] kp;
        logic [15:0] kd;
    } cfg_t;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] first;
        logic [7:0] last;
    } row_stat_t;

    typedef row_stat_t [NUM_ROWS-1:0] row_stats_t;

    localparam row_stat_t ROW_CLEAR = '{count: 8'd0, first: NO_EDGE, last: NO_EDGE};

endpackage

@@ design/lcps_ifs.sv @@
interface lcps_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic [5:0] row;
    logic [7:0] col;
    logic       frame_end;

    modport source (output valid, pixel, row, col, frame_end, input ready);
    modport sink   (input valid, pixel, row, col, frame_end, output ready);
endinterface

interface lcps_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_width;
    logic [7:0]  line_center;
    logic [1:0]  center_source;

    modport source (output valid, pulse_width, line_center, center_source, input ready);
    modport sink   (input valid, pulse_width, line_center, center_source, output ready);
endinterface

interface lcps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/lcps_cfg_regs.sv @@
module lcps_cfg_regs
    import lcps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lcps_cfg_if.sink    cfg,
    output cfg_t        cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TOP_ROW:    cfg_next.top_row    = cfg.data[5:0];
                REG_MIDDLE_ROW: cfg_next.middle_row = cfg.data[5:0];
                REG_BOTTOM_ROW: cfg_next.bottom_row = cfg.data[5:0];
                REG_PROP_GAIN:  cfg_next.kp         = cfg.data;
                REG_DERIV_GAIN: cfg_next.kd         = cfg.data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_row    <= 6'd5;
            cfg_reg.middle_row <= 6'd20;
            cfg_reg.bottom_row <= 6'd35;
            cfg_reg.kp         <= 16'd1536;
            cfg_reg.kd         <= 16'd3584;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/lcps_row_scan.sv @@
module lcps_row_scan
    import lcps_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH = IMAGE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lcps_pix_if.sink   pixels,
    input  cfg_t       cfg_q,
    output row_stats_t snap,
    output logic       snap_valid,
    input  logic       snap_ready
);

    localparam logic [7:0] COL_LAST = 8'(IMAGE_WIDTH - 2);

    logic       a_valid_reg;
    logic [7:0] a_pixel_reg;
    logic [5:0] a_row_reg;
    logic [7:0] a_col_reg;
    logic       a_fend_reg;

    row_stats_t stats_reg;
    row_stats_t stats_next;
    row_stats_t stats_upd;
    logic       prev_black_reg;
    logic       prev_black_next;
    row_stats_t snap_reg;
    logic       snap_valid_reg;

    logic       snap_free;
    logic       a_free;
    logic       a_fire;
    logic       black;
    logic       in_range;
    logic [5:0] watch_rows [NUM_ROWS];

    assign snap_free     = !snap_valid_reg || snap_ready;
    assign a_free        = !a_valid_reg || !a_fend_reg || snap_free;
    assign a_fire        = a_valid_reg && a_free;
    assign pixels.ready  = a_free;
    assign snap          = snap_reg;
    assign snap_valid    = snap_valid_reg;

    assign watch_rows[0] = cfg_q.top_row;
    assign watch_rows[1] = cfg_q.middle_row;
    assign watch_rows[2] = cfg_q.bottom_row;

    assign black    = (a_pixel_reg == 8'd0);
    assign in_range = (a_col_reg >= 8'd1) && (a_col_reg <= COL_LAST);

    always_comb
    begin
        stats_upd = stats_reg;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            if (in_range && black && (a_row_reg == watch_rows[k]))
            begin
                if (stats_reg[k].count != COUNT_MAX)
                begin
                    stats_upd[k].count = stats_reg[k].count + 8'd1;
                end
                if (!prev_black_reg)
                begin
                    if (stats_reg[k].first == NO_EDGE)
                    begin
                        stats_upd[k].first = a_col_reg;
                    end
                    else
                    begin
                        stats_upd[k].last = a_col_reg;
                    end
                end
            end
        end
    end

    always_comb
    begin
        stats_next      = stats_reg;
        prev_black_next = prev_black_reg;
        if (a_fire)
        begin
            prev_black_next = black;
            stats_next      = a_fend_reg ? {NUM_ROWS{ROW_CLEAR}} : stats_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            stats_reg      <= {NUM_ROWS{ROW_CLEAR}};
            prev_black_reg <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= pixels.valid;
            end
            stats_reg      <= stats_next;
            prev_black_reg <= prev_black_next;
            if (snap_free)
            begin
                snap_valid_reg <= a_fire && a_fend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && pixels.valid)
        begin
            a_pixel_reg <= pixels.pixel;
            a_row_reg   <= pixels.row;
            a_col_reg   <= pixels.col;
            a_fend_reg  <= pixels.frame_end;
        end
        if (snap_free && a_fire && a_fend_reg)
        begin
            snap_reg <= stats_upd;
        end
    end

endmodule

@@ design/lcps_pd_calc.sv @@
module lcps_pd_calc
    import lcps_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH = IMAGE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  row_stats_t snap,
    input  logic       snap_valid,
    output logic       snap_ready,
    input  cfg_t       cfg_q,
    lcps_res_if.source results
);

    localparam logic [7:0] HALF_W   = 8'(IMAGE_WIDTH / 2);
    localparam logic [7:0] LAST_COL = 8'(IMAGE_WIDTH - 1);
    localparam logic [7:0] FAR_EDGE = 8'(IMAGE_WIDTH - 11);
    localparam logic [7:0] NEAR_LIM = 8'(BORDER_MARGIN);
    localparam logic [8:0] WIDTH9   = 9'(IMAGE_WIDTH);
    localparam logic signed [20:0] PULSE_BASE = $signed(21'(PULSE_CENTRE));

    logic [7:0]        prev_center_reg;
    logic [7:0]        row_centre [NUM_ROWS];
    logic [NUM_ROWS-1:0] row_ok;
    logic [7:0]        centre;
    src_t              source;
    logic signed [8:0] err;
    logic signed [9:0] derr;

    logic              b_valid_reg;
    logic signed [8:0] b_err_reg;
    logic signed [9:0] b_derr_reg;
    logic [7:0]        b_centre_reg;
    src_t              b_src_reg;

    logic               c_valid_reg;
    logic signed [25:0] c_p_reg;
    logic signed [26:0] c_d_reg;
    logic [7:0]         c_centre_reg;
    src_t               c_src_reg;

    logic               out_valid_reg;
    logic [15:0]        out_pw_reg;
    logic [7:0]         out_centre_reg;
    src_t               out_src_reg;

    logic               out_free;
    logic               c_free;
    logic               b_free;
    logic               b_load;
    logic signed [25:0] prod_p;
    logic signed [26:0] prod_d;
    logic signed [27:0] sum;
    logic signed [19:0] quot;
    logic signed [20:0] pw;
    logic [15:0]        pw_sat;

    assign out_free   = !out_valid_reg || results.ready;
    assign c_free     = !c_valid_reg || out_free;
    assign b_free     = !b_valid_reg || c_free;
    assign snap_ready = b_free;
    assign b_load     = snap_valid && b_free;

    always_comb
    begin
        logic [8:0] pair_sum;
        logic [8:0] far_sum;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            pair_sum  = {1'b0, snap[k].first} + {1'b0, snap[k].last};
            far_sum   = {1'b0, snap[k].first} + WIDTH9;
            row_ok[k] = (snap[k].count >= MIN_BLACK) && (snap[k].count <= MAX_BLACK);
            if (snap[k].last != NO_EDGE)
            begin
                row_centre[k] = pair_sum[8:1];
            end
            else if (snap[k].first < HALF_W)
            begin
                row_centre[k] = (snap[k].first < NEAR_LIM) ? 8'd0 : (snap[k].first >> 1);
            end
            else
            begin
                row_centre[k] = (snap[k].first > FAR_EDGE) ? LAST_COL : far_sum[8:1];
            end
        end
    end

    always_comb
    begin
        priority if (row_ok[0])
        begin
            centre = row_centre[0];
            source = SRC_TOP;
        end
        else if (row_ok[1])
        begin
            centre = row_centre[1];
            source = SRC_MIDDLE;
        end
        else if (row_ok[2])
        begin
            centre = row_centre[2];
            source = SRC_BOTTOM;
        end
        else
        begin
            centre = prev_center_reg;
            source = SRC_HELD;
        end
    end

    assign err  = $signed({1'b0, HALF_W}) - $signed({1'b0, centre});
    assign derr = $signed({2'b00, prev_center_reg}) - $signed({2'b00, centre});

    assign prod_p = $signed({1'b0, cfg_q.kp}) * b_err_reg;
    assign prod_d = $signed({1'b0, cfg_q.kd}) * b_derr_reg;

    assign sum  = c_p_reg + c_d_reg;
    assign quot = sum[27:8];
    assign pw   = quot + PULSE_BASE;

    always_comb
    begin
        priority if (pw[20])
        begin
            pw_sat = 16'd0;
        end
        else if (pw[19:16] != 4'd0)
        begin
            pw_sat = 16'hFFFF;
        end
        else
        begin
            pw_sat = pw[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_center_reg <= 8'd0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (b_load)
            begin
                prev_center_reg <= centre;
            end
            if (b_free)
            begin
                b_valid_reg <= snap_valid;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_err_reg    <= err;
            b_derr_reg   <= derr;
            b_centre_reg <= centre;
            b_src_reg    <= source;
        end
        if (c_free && b_valid_reg)
        begin
            c_p_reg      <= prod_p;
            c_d_reg      <= prod_d;
            c_centre_reg <= b_centre_reg;
            c_src_reg    <= b_src_reg;
        end
        if (out_free && c_valid_reg)
        begin
            out_pw_reg     <= pw_sat;
            out_centre_reg <= c_centre_reg;
            out_src_reg    <= c_src_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.pulse_width   = out_pw_reg;
    assign results.line_center   = out_centre_reg;
    assign results.center_source = out_src_reg;

endmodule

@@ design/line_center_pd_steering.sv @@
// A frame_end beat passes the A and snapshot registers, then the steering maths pipeline
// (stages B, C and output), to its result beat. Throughput: one pixel beat per cycle while
// the snapshot is free; row counting and edge capture are one compare and counter update per beat.
// Reset (rst_n low, asynchronous): row counters and edges cleared, held centre zero,
// registers to their reset values, pipeline emptied; configuration writes never stall.
module line_center_pd_steering
    import lcps_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH = IMAGE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lcps_pix_if.sink   pixels,
    lcps_res_if.source results,
    lcps_cfg_if.sink   cfg
);

    localparam logic [2:0] PIPE_DEPTH = 3'd5;

    cfg_t       cfg_q;
    row_stats_t snap;
    logic       snap_valid;
    logic       snap_ready;

    lcps_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    lcps_row_scan #(.IMAGE_WIDTH(IMAGE_WIDTH)) u_row_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg_q      (cfg_q),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    lcps_pd_calc #(.IMAGE_WIDTH(IMAGE_WIDTH)) u_pd_calc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .cfg_q      (cfg_q),
        .results    (results)
    );

    // frames between an accepted frame_end beat and its result beat
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       frame_in;
    logic       frame_out;

    assign frame_in  = pixels.valid && pixels.ready && pixels.frame_end;
    assign frame_out = results.valid && results.ready;

    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, frame_in} - {2'b00, frame_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_result_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (inflight_reg != 3'd0))
        else $error("result beat with no frame in flight");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= PIPE_DEPTH)
        else $error("more frames in flight than pipeline stages");

    a_stall_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (inflight_reg != 3'd0))
        else $error("pixel input stalled with no frame in flight");

endmodule
